FILE: design/ps2mt_pkg.sv
`default_nettype none

package ps2mt_pkg;

  // Cursor footprint in pixels, taken off the screen size for the clamp
  localparam int CURSOR_SIZE = 10;

  // Cursor position after reset
  localparam logic [9:0] RESET_COL = 10'd160;
  localparam logic [9:0] RESET_ROW = 10'd100;

  // Configuration register defaults
  localparam logic [9:0] RESET_SCREEN_W = 10'd320;
  localparam logic [9:0] RESET_SCREEN_H = 10'd200;

  // Configuration register indexes (word address bits)
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_GRAPHICS_ON   = 2'd2;

  // Header byte bit positions
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

  // One complete packet, handed from the byte assembler to the cursor unit
  typedef struct packed {
    logic       track;    // graphics mode was on when the packet closed
    logic       x_sign;
    logic       y_sign;
    logic [2:0] buttons;
    logic [7:0] x_low;
    logic [7:0] y_low;
  } packet_t;

  // Clamp a position to 0 .. size - CURSOR_SIZE, with a negative limit taken as 0
  function automatic logic [9:0] clamp_pos(logic signed [11:0] pos, logic [9:0] size);
    logic signed [11:0] lim;
    logic signed [11:0] p;
    lim = $signed({2'b00, size}) - $signed(12'(CURSOR_SIZE));
    if (lim < 0) lim = '0;
    p = pos;
    if (p < 0) p = '0;
    if (p >= lim) p = lim;
    return p[9:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/ps2mt_if.sv
`default_nettype none

// Byte channel from the mouse link
interface ps2mt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Cursor update channel
interface ps2mt_cursor_if;
  logic       valid;
  logic       ready;
  logic [9:0] new_x;
  logic [9:0] new_y;
  logic [9:0] prev_x;
  logic [9:0] prev_y;
  logic       restore_prev;
  logic [2:0] button_bits;

  modport source (output valid, output new_x, output new_y, output prev_x, output prev_y,
                  output restore_prev, output button_bits, input ready);
  modport sink (input valid, input new_x, input new_y, input prev_x, input prev_y,
                input restore_prev, input button_bits, output ready);
endinterface

`default_nettype wire

FILE: design/ps2mt_front.sv
`default_nettype none

module ps2mt_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ps2mt_byte_if.sink             rx_in,
  input  wire logic              graphics_on_i,
  input  wire logic              queue_full_i,
  output logic                   push_o,
  output ps2mt_pkg::packet_t     push_pkt_o
);
  import ps2mt_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XDELTA = 3'b010,
    PH_YDELTA = 3'b100
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] header_q, header_d;
  logic [7:0] x_low_q, x_low_d;
  logic       accept;

  // Take a word whenever the queue has room for a finished packet
  assign rx_in.ready = !queue_full_i;
  assign accept      = rx_in.valid && rx_in.ready;

  // Walk the three-word packet, syncing on a header with bit 3 set
  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    x_low_d  = x_low_q;
    push_o   = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_XDELTA: begin
          x_low_d = rx_in.rx_byte;
          phase_d = PH_YDELTA;
        end
        PH_YDELTA: begin
          push_o  = 1'b1;
          phase_d = PH_HEADER;
        end
        default: begin
          if (rx_in.rx_byte[HDR_SYNC_BIT]) begin
            header_d = rx_in.rx_byte;
            phase_d  = PH_XDELTA;
          end else begin
            phase_d = PH_HEADER;
          end
        end
      endcase
    end
  end

  // Build the packet from the held words and the closing word
  always_comb begin
    push_pkt_o.track   = graphics_on_i;
    push_pkt_o.x_sign  = header_q[HDR_XSIGN_BIT];
    push_pkt_o.y_sign  = header_q[HDR_YSIGN_BIT];
    push_pkt_o.buttons = header_q[2:0];
    push_pkt_o.x_low   = x_low_q;
    push_pkt_o.y_low   = rx_in.rx_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      header_q <= '0;
      x_low_q  <= '0;
    end else begin
      phase_q  <= phase_d;
      header_q <= header_d;
      x_low_q  <= x_low_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ps2mt_queue.sv
`default_nettype none

module ps2mt_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ps2mt_pkg::packet_t push_pkt_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  wire logic              pop_i,
  output ps2mt_pkg::packet_t     pop_pkt_o
);
  import ps2mt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  packet_t            slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_pkt_o = slot_q[rd_ptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // Store a packet at the write pointer
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_pkt_i;
  end

  // Advance pointers and track fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ps2mt_back.sv
`default_nettype none

module ps2mt_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [9:0]         screen_width_i,
  input  wire logic [9:0]         screen_height_i,
  input  wire logic               pkt_valid_i,
  input  wire ps2mt_pkg::packet_t pkt_i,
  output logic                    pop_o,
  ps2mt_cursor_if.source          cur_out
);
  import ps2mt_pkg::*;

  logic [9:0]         col_q, row_q;
  logic               shown_q;
  logic               out_valid_q, out_valid_d;
  logic [9:0]         new_x_q, new_y_q, prev_x_q, prev_y_q;
  logic               restore_q;
  logic [2:0]         buttons_q;
  logic signed [11:0] x_sum, y_sum;
  logic [9:0]         col_next, row_next;
  logic               emit;

  // Take a packet when the output word is free or leaving this cycle
  assign pop_o = pkt_valid_i && (!out_valid_q || cur_out.ready);
  assign emit  = pop_o && pkt_i.track;

  // Add X, subtract Y, then clamp both against the screen
  assign x_sum    = $signed({2'b00, col_q}) + $signed({{4{pkt_i.x_sign}}, pkt_i.x_low});
  assign y_sum    = $signed({2'b00, row_q}) - $signed({{4{pkt_i.y_sign}}, pkt_i.y_low});
  assign col_next = clamp_pos(x_sum, screen_width_i);
  assign row_next = clamp_pos(y_sum, screen_height_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (cur_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold cursor state; a packet in text mode only hides the cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= RESET_COL;
      row_q       <= RESET_ROW;
      shown_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (emit) begin
        col_q   <= col_next;
        row_q   <= row_next;
        shown_q <= 1'b1;
      end else if (pop_o) begin
        shown_q <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk_i) begin
    if (emit) begin
      new_x_q   <= col_next;
      new_y_q   <= row_next;
      prev_x_q  <= col_q;
      prev_y_q  <= row_q;
      restore_q <= shown_q;
      buttons_q <= pkt_i.buttons;
    end
  end

  assign cur_out.valid        = out_valid_q;
  assign cur_out.new_x        = new_x_q;
  assign cur_out.new_y        = new_y_q;
  assign cur_out.prev_x       = prev_x_q;
  assign cur_out.prev_y       = prev_y_q;
  assign cur_out.restore_prev = restore_q;
  assign cur_out.button_bits  = buttons_q;

endmodule

`default_nettype wire

FILE: design/ps2_mouse_packet_tracker.sv
// Channel  | Dir | Handshake     | Word contents
// ---------+-----+---------------+----------------------------------------------
// rx_in    | in  | valid/ready   | rx_byte
// cur_out  | out | valid/ready   | new_x new_y prev_x prev_y restore_prev
//          |     |               | button_bits
// APB      | in  | psel/penable  | screen_width(0x0) screen_height(0x4) graphics_on(0x8)
//
// One word is taken per cycle while the queue is not full. The third word of a
// packet lands in the queue, and the cursor unit turns it into a registered
// output word once the output word is free. The queue lets the front
// keep taking words while the output word waits; it stalls only when full.
// Reset clears the phase, the queue and the output valid; no clearing pass.
`default_nettype none

module ps2_mouse_packet_tracker #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ps2mt_byte_if.sink       rx_in,
  ps2mt_cursor_if.source   cur_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ps2mt_pkg::*;

  logic [9:0] screen_w_q, screen_h_q;
  logic       graphics_on_q;
  logic       cfg_write;
  logic       push, full, q_valid, pop;
  packet_t    push_pkt, pop_pkt;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q    <= RESET_SCREEN_W;
      screen_h_q    <= RESET_SCREEN_H;
      graphics_on_q <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SCREEN_WIDTH:  screen_w_q    <= pwdata[9:0];
        REG_SCREEN_HEIGHT: screen_h_q    <= pwdata[9:0];
        REG_GRAPHICS_ON:   graphics_on_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_SCREEN_WIDTH:  prdata = {22'd0, screen_w_q};
      REG_SCREEN_HEIGHT: prdata = {22'd0, screen_h_q};
      REG_GRAPHICS_ON:   prdata = {31'd0, graphics_on_q};
      default:           prdata = '0;
    endcase
  end

  ps2mt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_in         (rx_in),
    .graphics_on_i (graphics_on_q),
    .queue_full_i  (full),
    .push_o        (push),
    .push_pkt_o    (push_pkt)
  );

  ps2mt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (full),
    .valid_o    (q_valid),
    .pop_i      (pop),
    .pop_pkt_o  (pop_pkt)
  );

  ps2mt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .screen_width_i  (screen_w_q),
    .screen_height_i (screen_h_q),
    .pkt_valid_i     (q_valid),
    .pkt_i           (pop_pkt),
    .pop_o           (pop),
    .cur_out         (cur_out)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import ps2mt_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_SEGMENTS = 8;
  localparam int SEGMENT_WORDS = 88;

  // One cursor update word as seen on the output channel
  typedef struct packed {
    logic [9:0] new_x;
    logic [9:0] new_y;
    logic [9:0] prev_x;
    logic [9:0] prev_y;
    logic       restore_prev;
    logic [2:0] button_bits;
  } cursor_word_t;

  // Track the packet assembler and cursor position, queue the expected updates
  class cursor_scoreboard;
    logic [9:0] scr_w;
    logic [9:0] scr_h;
    logic       gfx_on;
    logic [1:0] phase;
    logic [7:0] hdr_byte;
    logic [7:0] x_byte;
    logic [9:0] col;
    logic [9:0] row;
    logic       shown;
    logic [2:0] btns;
    cursor_word_t pending_moves[$];
    int errors;

    function new();
      scr_w = RESET_SCREEN_W;
      scr_h = RESET_SCREEN_H;
      gfx_on = 1'b1;
      phase = 2'd0;
      hdr_byte = 8'h00;
      x_byte = 8'h00;
      col = RESET_COL;
      row = RESET_ROW;
      shown = 1'b0;
      btns = 3'd0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [9:0] val);
      case (idx)
        REG_SCREEN_WIDTH: scr_w = val;
        REG_SCREEN_HEIGHT: scr_h = val;
        REG_GRAPHICS_ON: gfx_on = val[0];
        default: ;
      endcase
    endfunction

    // Hold a coordinate within 0 .. size - cursor, a negative limit counts as 0
    function logic [9:0] clamp_to(int pos, logic [9:0] size);
      int lim;
      lim = int'(size) - CURSOR_SIZE;
      if (lim < 0) lim = 0;
      if (pos < 0) pos = 0;
      if (pos > lim) pos = lim;
      return 10'(pos);
    endfunction

    // Advance the assembler by one word; return 1 unless the word was dropped
    function bit take_byte(logic [7:0] b);
      int dx;
      int dy;
      cursor_word_t w;
      if (phase == 2'd1) begin
        x_byte = b;
        phase = 2'd2;
        return 1'b1;
      end
      if (phase != 2'd2) begin
        if (b[HDR_SYNC_BIT]) begin
          hdr_byte = b;
          phase = 2'd1;
          return 1'b1;
        end
        phase = 2'd0;
        return 1'b0;
      end
      phase = 2'd0;
      if (!gfx_on) begin
        shown = 1'b0;
        return 1'b1;
      end
      dx = int'($signed({hdr_byte[HDR_XSIGN_BIT], x_byte}));
      dy = int'($signed({hdr_byte[HDR_YSIGN_BIT], b}));
      w.prev_x = col;
      w.prev_y = row;
      col = clamp_to(int'(col) + dx, scr_w);
      row = clamp_to(int'(row) - dy, scr_h);
      btns = hdr_byte[2:0];
      w.new_x = col;
      w.new_y = row;
      w.restore_prev = shown;
      w.button_bits = btns;
      pending_moves.push_back(w);
      shown = 1'b1;
      return 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(cursor_word_t got);
      cursor_word_t want;
      if (pending_moves.size() == 0) begin
        report($sformatf("cursor word with nothing pending: %h", got));
        return;
      end
      want = pending_moves.pop_front();
      if (got.new_x !== want.new_x)
        report($sformatf("new_x got %0d want %0d", got.new_x, want.new_x));
      if (got.new_y !== want.new_y)
        report($sformatf("new_y got %0d want %0d", got.new_y, want.new_y));
      if (got.prev_x !== want.prev_x)
        report($sformatf("prev_x got %0d want %0d", got.prev_x, want.prev_x));
      if (got.prev_y !== want.prev_y)
        report($sformatf("prev_y got %0d want %0d", got.prev_y, want.prev_y));
      if (got.restore_prev !== want.restore_prev)
        report($sformatf("restore_prev got %0b want %0b", got.restore_prev,
                         want.restore_prev));
      if (got.button_bits !== want.button_bits)
        report($sformatf("button_bits got %0d want %0d", got.button_bits,
                         want.button_bits));
    endtask

    function int pending();
      return pending_moves.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ps2mt_byte_if rx_if ();
  ps2mt_cursor_if cur_if ();

  cursor_scoreboard sb = new();
  bit idle_on;
  int words_used;
  int stall_left;
  int cycle_cnt;

  ps2_mouse_packet_tracker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_in   (rx_if),
    .cur_out (cur_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check accepted cursor words and stall the output side in random bursts
  always @(posedge clk_i) begin : cursor_sink
    cursor_word_t seen;
    if (rst_ni) begin
      if (cur_if.valid && cur_if.ready) begin
        seen.new_x = cur_if.new_x;
        seen.new_y = cur_if.new_y;
        seen.prev_x = cur_if.prev_x;
        seen.prev_y = cur_if.prev_y;
        seen.restore_prev = cur_if.restore_prev;
        seen.button_bits = cur_if.button_bits;
        sb.check_word(seen);
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        cur_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        cur_if.ready <= 1'b0;
      end else begin
        cur_if.ready <= 1'b1;
      end
    end
  end

  // Present one word, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    words_used += int'(sb.take_byte(b));
  endtask

  task automatic send_packet(input logic [7:0] hdr, input logic [7:0] xl,
                             input logic [7:0] yl);
    send_byte(hdr);
    send_byte(xl);
    send_byte(yl);
  endtask

  // Hold the input until every update is out, then let the pipeline empty
  task automatic settle();
    rx_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [9:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_screen(input logic [9:0] w, input logic [9:0] h, input logic g);
    settle();
    reg_write(REG_SCREEN_WIDTH, w);
    reg_write(REG_SCREEN_HEIGHT, h);
    reg_write(REG_GRAPHICS_ON, {9'd0, g});
  endtask

  // Pick a 9-bit delta: either any value or a small step either way
  function automatic logic [8:0] pick_delta();
    int m;
    if ($urandom_range(0, 1) == 1) return 9'($urandom_range(0, 511));
    m = $urandom_range(0, 8);
    if ($urandom_range(0, 1) == 1) return 9'(512 - m);
    return 9'(m);
  endfunction

  task automatic send_random_packet();
    logic [7:0] hdr;
    logic [8:0] dx;
    logic [8:0] dy;
    hdr = 8'($urandom_range(0, 255));
    dx = pick_delta();
    dy = pick_delta();
    hdr[HDR_SYNC_BIT] = 1'b1;
    hdr[HDR_XSIGN_BIT] = dx[8];
    hdr[HDR_YSIGN_BIT] = dy[8];
    send_packet(hdr, dx[7:0], dy[7:0]);
  endtask

  initial begin
    logic [9:0] seg_w;
    logic [9:0] seg_h;
    logic seg_g;
    int target;
    rst_ni = 1'b0;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = 8'h00;
    cur_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'h0;
    pwdata = 32'h0;
    idle_on = 1'b1;
    words_used = 0;
    stall_left = 0;
    cycle_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dropped headers, zero move, extreme deltas, buttons, overflow bits
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h00, 8'h00);
    send_packet(8'h2F, 8'h7F, 8'h80);
    send_packet(8'h18, 8'h00, 8'h00);
    send_packet(8'hFF, 8'hFF, 8'hFF);
    send_packet(8'h08, 8'hFF, 8'hFF);
    send_packet(8'h3A, 8'h80, 8'h01);
    // Packet closing with graphics off hides the cursor
    settle();
    reg_write(REG_GRAPHICS_ON, 10'd0);
    send_packet(8'h09, 8'h01, 8'h01);
    settle();
    reg_write(REG_GRAPHICS_ON, 10'd1);
    send_packet(8'h0C, 8'h05, 8'hFB);

    // Random segments, each under its own screen setting
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      case (seg)
        0: begin seg_w = 10'd1023; seg_h = 10'd1023; seg_g = 1'b1; end
        1: begin seg_w = 10'd16; seg_h = 10'd16; seg_g = 1'b1; end
        2: begin seg_w = 10'd5; seg_h = 10'd0; seg_g = 1'b1; end
        3: begin
          seg_w = 10'($urandom_range(16, 1023));
          seg_h = 10'($urandom_range(16, 1023));
          seg_g = 1'b0;
        end
        5: begin seg_w = 10'd640; seg_h = 10'd480; seg_g = 1'b1; end
        7: begin seg_w = 10'd320; seg_h = 10'd200; seg_g = 1'b1; end
        default: begin
          seg_w = 10'($urandom_range(0, 1023));
          seg_h = 10'($urandom_range(0, 1023));
          seg_g = 1'b1;
        end
      endcase
      set_screen(seg_w, seg_h, seg_g);
      idle_on = (seg != NUM_SEGMENTS - 1) && (seg % 3 != 1);
      target = words_used + SEGMENT_WORDS;
      while (words_used < target) begin
        if ($urandom_range(0, 9) < 8) send_random_packet();
        else send_byte(8'($urandom_range(0, 255)));
        // In segment 4, pause mid-segment until all updates are out
        if (seg == 4 && words_used >= target - SEGMENT_WORDS / 2 && sb.pending() != 0)
          settle();
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/ps2mt_pkg.sv
design/ps2mt_if.sv
design/ps2mt_front.sv
design/ps2mt_queue.sv
design/ps2mt_back.sv
design/ps2_mouse_packet_tracker.sv
tb/sv/tb_top.sv
